>>> rtl/core/jpeg_block_entropy_coder_defines.svh
// assertion macros used by the port-level checker file
`ifndef JPEG_BLOCK_ENTROPY_CODER_DEFINES_SVH
`define JPEG_BLOCK_ENTROPY_CODER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define JBEC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JBEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/jbec_pkg.sv
// types, constants and helper functions of the jpeg entropy coder
`default_nettype none

package jbec_pkg;

    localparam logic [1:0] CMD_COEF  = 2'd0;
    localparam logic [1:0] CMD_DC_WR = 2'd1;
    localparam logic [1:0] CMD_AC_WR = 2'd2;

    localparam int DC_DEPTH = 12;
    localparam int AC_DEPTH = 256;

    localparam logic [7:0] SYM_ZRL = 8'hF0;
    localparam logic [7:0] SYM_EOB = 8'h00;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [4:0] CODE_LEN_MAX = 5'd16;

    typedef struct packed {
        logic [15:0] code;
        logic [4:0]  len;
    } code_entry_t;

    typedef struct packed {
        logic        rd_en;
        logic [3:0]  dc_rd_addr;
        logic [7:0]  ac_rd_addr;
        logic        dc_wr_en;
        logic [3:0]  dc_wr_addr;
        logic        ac_wr_en;
        logic [7:0]  ac_wr_addr;
        code_entry_t wr_entry;
    } store_req_t;

    typedef struct packed {
        code_entry_t dc_entry;
        code_entry_t zrl_entry;
        code_entry_t ac_entry;
    } store_rsp_t;

    typedef struct packed {
        logic        code_dc;
        logic [1:0]  zrl_cnt;
        logic        do_mag;
        logic [10:0] mag_bits;
        logic [3:0]  mag_cnt;
    } chunk_job_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ZRL,
        SEQ_CODE,
        SEQ_MAG
    } seq_state_t;

    function automatic logic [15:0] low_mask16(input logic [4:0] n);
        logic [16:0] m;
        m = (17'd1 << n) - 17'd1;
        return m[15:0];
    endfunction

    // bit length of a magnitude
    function automatic logic [3:0] category11(input logic [10:0] a);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 11; i++)
        begin
            if (a[i])
            begin
                c = 4'(i + 1);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/jbec_if.sv
// valid/ready channel interfaces for coefficient items and code chunks
`default_nettype none

interface jbec_coef_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [10:0] coef_value;
    logic [7:0]         table_index;
    logic [15:0]        code_bits;
    logic [4:0]         code_length;

    modport source (
        output valid, cmd, coef_value, table_index, code_bits, code_length,
        input  ready
    );
    modport sink (
        input  valid, cmd, coef_value, table_index, code_bits, code_length,
        output ready
    );
endinterface

interface jbec_chunk_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_bits;
    logic [4:0]  out_count;
    logic        missing_code;
    logic        last;

    modport source (
        output valid, out_bits, out_count, missing_code, last,
        input  ready
    );
    modport sink (
        input  valid, out_bits, out_count, missing_code, last,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/jpeg_block_entropy_coder.sv
// Baseline JPEG Huffman entropy coder for one component stream. Coefficient items arrive
// in zigzag order, 64 per block; command items load DC (12 entries) and AC (256 entries)
// code tables held in two synchronous memories with per-entry valid bits, so no clearing
// pass is needed after reset. A coefficient item that yields code chunks (up to five:
// ZRL codes, run/size or DC code, magnitude bits) holds the block until its last chunk
// is moved into the output register, one chunk at a time; the code table read overlaps
// with the previous item's final chunk. Table writes, unused commands and AC zeros that
// yield no chunk leave the sequencer idle. A stall on the chunk side holds the sequencer.
`default_nettype none

module jpeg_block_entropy_coder (
    input  logic         clk,
    input  logic         rst_n,
    jbec_coef_if.sink    coef,
    jbec_chunk_if.source chunk
);
    import jbec_pkg::*;

    logic [10:0] dc_pred_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  run_reg;

    logic        seq_ready;
    logic        accept;
    logic        coef_accept;
    logic        is_dc;
    logic        v_zero;
    logic        has_chunks;
    logic [4:0]  len_clamped;
    logic [11:0] diff;
    logic [11:0] sel_val;
    logic [11:0] abs_val;
    logic [11:0] mag_raw;
    logic [3:0]  cat;
    logic [15:0] cat_mask;
    logic [7:0]  ac_addr;
    chunk_job_t  job;
    store_req_t  req;
    store_rsp_t  rsp;

    assign coef.ready  = seq_ready;
    assign accept      = coef.valid && seq_ready;
    assign coef_accept = accept && (coef.cmd == CMD_COEF);

    assign len_clamped = (coef.code_length > CODE_LEN_MAX) ? CODE_LEN_MAX : coef.code_length;

    assign is_dc   = (pos_reg == 6'd0);
    assign v_zero  = (coef.coef_value == 11'sd0);
    assign diff    = {coef.coef_value[10], coef.coef_value} - {dc_pred_reg[10], dc_pred_reg};
    assign sel_val = is_dc ? diff : {coef.coef_value[10], coef.coef_value};
    assign abs_val = sel_val[11] ? (12'd0 - sel_val) : sel_val;
    assign cat     = category11(abs_val[10:0]);
    // negative values send the low bits of value minus one
    assign mag_raw  = sel_val[11] ? (sel_val - 12'd1) : sel_val;
    assign cat_mask = low_mask16({1'b0, cat});

    always_comb
    begin
        has_chunks    = 1'b0;
        ac_addr       = {run_reg[3:0], cat};
        job.code_dc   = 1'b0;
        job.zrl_cnt   = 2'd0;
        job.do_mag    = 1'b0;
        job.mag_bits  = mag_raw[10:0] & cat_mask[10:0];
        job.mag_cnt   = cat;
        priority if (is_dc)
        begin
            has_chunks  = 1'b1;
            job.code_dc = 1'b1;
            job.do_mag  = (cat != 4'd0);
        end
        else if (v_zero)
        begin
            // end of block code only on the last position
            has_chunks = (pos_reg == LAST_POS);
            ac_addr    = SYM_EOB;
        end
        else
        begin
            has_chunks  = 1'b1;
            job.zrl_cnt = run_reg[5:4];
            job.do_mag  = 1'b1;
        end
    end

    always_comb
    begin
        req.rd_en      = coef_accept;
        req.dc_rd_addr = cat;
        req.ac_rd_addr = ac_addr;
        req.dc_wr_en   = accept && (coef.cmd == CMD_DC_WR)
                         && (32'(coef.table_index) < DC_DEPTH);
        req.dc_wr_addr = coef.table_index[3:0];
        req.ac_wr_en   = accept && (coef.cmd == CMD_AC_WR);
        req.ac_wr_addr = coef.table_index;
        req.wr_entry   = {coef.code_bits, len_clamped};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_pred_reg <= 11'd0;
            pos_reg     <= 6'd0;
            run_reg     <= 6'd0;
        end
        else if (coef_accept)
        begin
            pos_reg <= pos_reg + 6'd1;
            priority if (is_dc)
            begin
                dc_pred_reg <= coef.coef_value;
                run_reg     <= 6'd0;
            end
            else if (v_zero)
            begin
                run_reg <= run_reg + 6'd1;
            end
            else
            begin
                run_reg <= 6'd0;
            end
        end
    end

    jbec_code_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    jbec_chunk_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (coef_accept && has_chunks),
        .job   (job),
        .rsp   (rsp),
        .ready (seq_ready),
        .chunk (chunk)
    );

endmodule

`default_nettype wire

>>> rtl/core/jbec_code_store.sv
// dc and ac code table memories with per-entry valid bits and registered reads
`default_nettype none

module jbec_code_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jbec_pkg::store_req_t req,
    output jbec_pkg::store_rsp_t rsp
);
    import jbec_pkg::*;

    code_entry_t dc_mem [DC_DEPTH];
    code_entry_t ac_mem [AC_DEPTH];

    logic [DC_DEPTH-1:0] dc_valid_reg;
    logic [AC_DEPTH-1:0] ac_valid_reg;

    code_entry_t dc_q_reg;
    code_entry_t zrl_q_reg;
    code_entry_t ac_q_reg;
    logic        dc_qv_reg;
    logic        zrl_qv_reg;
    logic        ac_qv_reg;

    always_ff @(posedge clk)
    begin
        if (req.dc_wr_en)
        begin
            dc_mem[req.dc_wr_addr] <= req.wr_entry;
        end
        if (req.ac_wr_en)
        begin
            ac_mem[req.ac_wr_addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            dc_q_reg  <= dc_mem[req.dc_rd_addr];
            zrl_q_reg <= ac_mem[SYM_ZRL];
            ac_q_reg  <= ac_mem[req.ac_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_valid_reg <= '0;
            ac_valid_reg <= '0;
            dc_qv_reg    <= 1'b0;
            zrl_qv_reg   <= 1'b0;
            ac_qv_reg    <= 1'b0;
        end
        else
        begin
            if (req.dc_wr_en)
            begin
                dc_valid_reg[req.dc_wr_addr] <= 1'b1;
            end
            if (req.ac_wr_en)
            begin
                ac_valid_reg[req.ac_wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                dc_qv_reg  <= dc_valid_reg[req.dc_rd_addr];
                zrl_qv_reg <= ac_valid_reg[SYM_ZRL];
                ac_qv_reg  <= ac_valid_reg[req.ac_rd_addr];
            end
        end
    end

    // an entry never written reads as length zero
    assign rsp.dc_entry  = dc_qv_reg  ? dc_q_reg  : '0;
    assign rsp.zrl_entry = zrl_qv_reg ? zrl_q_reg : '0;
    assign rsp.ac_entry  = ac_qv_reg  ? ac_q_reg  : '0;

endmodule

`default_nettype wire

>>> rtl/core/jbec_chunk_seq.sv
// chunk sequencer: walks zrl, code and magnitude chunks into the output register
`default_nettype none

module jbec_chunk_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  jbec_pkg::chunk_job_t job,
    input  jbec_pkg::store_rsp_t rsp,
    output logic                 ready,
    jbec_chunk_if.source         chunk
);
    import jbec_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [1:0]  zrl_left_reg, zrl_left_next;
    chunk_job_t  job_reg;

    logic        out_valid_reg;
    logic [15:0] out_bits_reg;
    logic [4:0]  out_count_reg;
    logic        out_missing_reg;
    logic        out_last_reg;

    code_entry_t cur_entry;
    logic        cur_is_code;
    logic [15:0] cur_bits;
    logic [4:0]  cur_count;
    logic        cur_missing;
    logic        cur_last;
    logic        load;

    // chunk presented by the current state
    always_comb
    begin
        cur_entry   = '0;
        cur_is_code = 1'b0;
        cur_last    = 1'b0;
        cur_bits    = 16'd0;
        cur_count   = 5'd0;
        cur_missing = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                cur_is_code = 1'b0;
            end
            SEQ_ZRL:
            begin
                cur_entry   = rsp.zrl_entry;
                cur_is_code = 1'b1;
            end
            SEQ_CODE:
            begin
                cur_entry   = job_reg.code_dc ? rsp.dc_entry : rsp.ac_entry;
                cur_is_code = 1'b1;
                cur_last    = !job_reg.do_mag;
            end
            SEQ_MAG:
            begin
                cur_bits  = {5'd0, job_reg.mag_bits};
                cur_count = {1'b0, job_reg.mag_cnt};
                cur_last  = 1'b1;
            end
        endcase
        if (cur_is_code)
        begin
            if (cur_entry.len == 5'd0)
            begin
                cur_missing = 1'b1;
            end
            else
            begin
                cur_bits  = cur_entry.code & low_mask16(cur_entry.len);
                cur_count = cur_entry.len;
            end
        end
    end

    assign load  = (state_reg != SEQ_IDLE) && (!out_valid_reg || chunk.ready);
    assign ready = (state_reg == SEQ_IDLE) || (load && cur_last);

    always_comb
    begin
        state_next    = state_reg;
        zrl_left_next = zrl_left_reg;
        priority if (start)
        begin
            zrl_left_next = job.zrl_cnt;
            state_next    = (job.zrl_cnt != 2'd0) ? SEQ_ZRL : SEQ_CODE;
        end
        else if (load)
        begin
            unique case (state_reg)
                SEQ_IDLE:
                begin
                    state_next = SEQ_IDLE;
                end
                SEQ_ZRL:
                begin
                    zrl_left_next = zrl_left_reg - 2'd1;
                    if (zrl_left_reg == 2'd1)
                    begin
                        state_next = SEQ_CODE;
                    end
                end
                SEQ_CODE:
                begin
                    state_next = job_reg.do_mag ? SEQ_MAG : SEQ_IDLE;
                end
                SEQ_MAG:
                begin
                    state_next = SEQ_IDLE;
                end
            endcase
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            zrl_left_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            zrl_left_reg <= zrl_left_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chunk.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job;
        end
        if (load)
        begin
            out_bits_reg    <= cur_bits;
            out_count_reg   <= cur_count;
            out_missing_reg <= cur_missing;
            out_last_reg    <= cur_last;
        end
    end

    assign chunk.valid        = out_valid_reg;
    assign chunk.out_bits     = out_bits_reg;
    assign chunk.out_count    = out_count_reg;
    assign chunk.missing_code = out_missing_reg;
    assign chunk.last         = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/jbec_checker.sv
// port-level checks on the chunk channel of the entropy coder, bound to the top level
`default_nettype none
`include "jpeg_block_entropy_coder_defines.svh"

module jbec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [15:0] out_bits,
    input logic [4:0]  out_count,
    input logic        missing_code
);

    `JBEC_ASSERT_NEXT(a_stall_hold, clk, rst_n, valid && !ready, valid && $stable(out_bits) && $stable(out_count) && $stable(missing_code), "chunk changed while stalled")
    `JBEC_ASSERT_SAME(a_missing_empty, clk, rst_n, valid && missing_code, out_bits == 16'd0, "missing code chunk carries bits")
    `JBEC_ASSERT_SAME(a_count_flag, clk, rst_n, valid, (missing_code == (out_count == 5'd0)) && (out_count <= 5'd16), "chunk count and missing flag disagree")
    `JBEC_ASSERT_SAME(a_bits_fit, clk, rst_n, valid && (out_count < 5'd16), (out_bits >> out_count) == 16'd0, "chunk bits above count")

endmodule

bind jpeg_block_entropy_coder jbec_checker u_jbec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (chunk.valid),
    .ready        (chunk.ready),
    .out_bits     (chunk.out_bits),
    .out_count    (chunk.out_count),
    .missing_code (chunk.missing_code)
);

`default_nettype wire

>>> tb/jbec_chunk_checker.sv
// scoreboard for the entropy coder: predicts the code chunks of each item and checks the output
`timescale 1ns / 1ps

module jbec_chunk_checker (
    input  logic  clk,
    input  logic  rst_n,
    jbec_coef_if  coef,
    jbec_chunk_if chunk,
    output int    mismatches,
    output int    outstanding
);
    import jbec_pkg::*;

    localparam int RUN_MAX    = 15;
    localparam int RUN_STEP   = 16;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [15:0] bits;
        logic [4:0]  count;
        logic        missing;
        logic        last;
    } chunk_t;

    logic signed [10:0] dc_pred;
    logic [5:0]         coef_pos;
    logic [5:0]         run_len;
    code_entry_t        dc_codes [DC_DEPTH];
    code_entry_t        ac_codes [AC_DEPTH];
    chunk_t             expected_chunks [$];
    chunk_t             seen;
    chunk_t             want;

    // size category: bit length of the magnitude, 0 for zero
    function automatic int unsigned size_cat(input int v);
        int unsigned a;
        int unsigned n;
        a = (v < 0) ? -v : v;
        n = 0;
        while (a != 0)
        begin
            n++;
            a >>= 1;
        end
        return n;
    endfunction

    // negative values are sent as one's complement in cat bits
    function automatic logic [15:0] extra_bits(input int v, input int unsigned cat);
        int m;
        m = (v >= 0) ? v : v + (1 << cat) - 1;
        return 16'(m & ((1 << cat) - 1));
    endfunction

    function automatic void add_chunk(input logic [15:0] bits, input int unsigned count,
                                      input logic missing);
        chunk_t c;
        c.bits    = bits & 16'((32'd1 << count) - 1);
        c.count   = 5'(count);
        c.missing = missing;
        c.last    = 1'b0;
        expected_chunks.insert(expected_chunks.size(), c);
    endfunction

    function automatic void add_code(input code_entry_t e);
        if (e.len == 5'd0)
            add_chunk(16'd0, 0, 1'b1);
        else
            add_chunk(e.code, e.len, 1'b0);
    endfunction

    function automatic void predict_chunks(input logic [1:0] cmd,
                                           input logic signed [10:0] value,
                                           input logic [7:0] idx,
                                           input logic [15:0] code,
                                           input logic [4:0] len);
        code_entry_t entry;
        int          diff;
        int unsigned cat;
        int          first;
        entry.code = code;
        entry.len  = (len > CODE_LEN_MAX) ? CODE_LEN_MAX : len;
        first      = expected_chunks.size();
        case (cmd)
            CMD_DC_WR:
            begin
                if (idx < DC_DEPTH)
                    dc_codes[idx] = entry;
            end
            CMD_AC_WR:
            begin
                ac_codes[idx] = entry;
            end
            CMD_COEF:
            begin
                if (coef_pos == 6'd0)
                begin
                    diff    = int'(value) - int'(dc_pred);
                    dc_pred = value;
                    run_len = 6'd0;
                    cat     = size_cat(diff);
                    add_code(dc_codes[cat]);
                    if (cat != 0)
                        add_chunk(extra_bits(diff, cat), cat, 1'b0);
                end
                else if (value == 11'sd0)
                begin
                    run_len = run_len + 6'd1;
                    if (coef_pos == LAST_POS)
                        add_code(ac_codes[SYM_EOB]);
                end
                else
                begin
                    while (run_len > RUN_MAX)
                    begin
                        add_code(ac_codes[SYM_ZRL]);
                        run_len = run_len - 6'(RUN_STEP);
                    end
                    cat = size_cat(int'(value));
                    add_code(ac_codes[{run_len[3:0], 4'(cat)}]);
                    add_chunk(extra_bits(int'(value), cat), cat, 1'b0);
                    run_len = 6'd0;
                end
                coef_pos = coef_pos + 6'd1;
            end
            default:
            begin
            end
        endcase
        if (expected_chunks.size() > first)
            expected_chunks[expected_chunks.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_pred  = '0;
            coef_pos = '0;
            run_len  = '0;
            foreach (dc_codes[i])
                dc_codes[i] = '0;
            foreach (ac_codes[i])
                ac_codes[i] = '0;
            expected_chunks.delete();
            mismatches = 0;
        end
        else
        begin
            // new expectations go to the back, so a chunk taken this edge still meets older ones
            if (coef.valid && coef.ready)
                predict_chunks(coef.cmd, coef.coef_value, coef.table_index,
                               coef.code_bits, coef.code_length);
            if (chunk.valid && chunk.ready)
            begin
                seen = {chunk.out_bits, chunk.out_count, chunk.missing_code, chunk.last};
                if (expected_chunks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t unexpected chunk: bits=%h count=%0d missing=%b last=%b",
                                 $time, seen.bits, seen.count, seen.missing, seen.last);
                end
                else
                begin
                    want = expected_chunks.pop_front();
                    if (seen.bits !== want.bits || seen.count !== want.count ||
                        seen.missing !== want.missing || seen.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t chunk mismatch: exp bits=%h count=%0d missing=%b last=%b",
                                     $time, want.bits, want.count, want.missing, want.last,
                                     " got bits=%h count=%0d missing=%b last=%b",
                                     seen.bits, seen.count, seen.missing, seen.last);
                    end
                end
            end
        end
        outstanding = expected_chunks.size();
    end

endmodule

>>> tb/tb.sv
// testbench top: clock, reset, coefficient and table stimulus and verdict for the entropy coder
`timescale 1ns / 1ps

module tb;
    import jbec_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int BLOCK_LEN    = 64;
    localparam int RAND_BLOCKS  = 3;
    localparam int TABLE_LOADS  = 24;

    typedef enum int {
        BLK_DENSE,
        BLK_SPARSE,
        BLK_TAIL
    } blk_kind_t;

    logic clk;
    logic rst_n;
    logic idle_on;
    logic hold_req;
    int   coef_idx;
    int   mismatches;
    int   outstanding;
    int   fails;

    jbec_coef_if  coef_ch ();
    jbec_chunk_if chunk_ch ();

    jpeg_block_entropy_coder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef_ch),
        .chunk (chunk_ch)
    );

    jbec_chunk_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef        (coef_ch),
        .chunk       (chunk_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] run_size(input int run, input int cat);
        return {4'(run), 4'(cat)};
    endfunction

    // nonzero most of the time, mostly small, now and then anywhere in range
    function automatic logic signed [10:0] rand_value();
        int unsigned r;
        int          m;
        r = $urandom_range(99);
        if (r >= 90)
            return 11'($urandom_range(2047));
        m = (r < 65) ? $urandom_range(1, 15) : $urandom_range(16, 255);
        return $urandom_range(1) ? 11'(m) : 11'(-m);
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input logic [1:0] cmd, input logic signed [10:0] value,
                             input logic [7:0] idx, input logic [15:0] code,
                             input logic [4:0] len);
        while (idle_on && $urandom_range(99) < 8)
        begin
            coef_ch.valid <= 1'b0;
            @(negedge clk);
        end
        coef_ch.valid       <= 1'b1;
        coef_ch.cmd         <= cmd;
        coef_ch.coef_value  <= value;
        coef_ch.table_index <= idx;
        coef_ch.code_bits   <= code;
        coef_ch.code_length <= len;
        do @(posedge clk); while (!coef_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_coef(input logic signed [10:0] value);
        send_item(CMD_COEF, value, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  5'($urandom_range(31)));
        coef_idx++;
    endtask

    task automatic send_rand_write();
        int unsigned pick;
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [4:0]  len;
        pick = $urandom_range(99);
        cmd  = CMD_AC_WR;
        if (pick < 25)
        begin
            cmd = CMD_DC_WR;
            idx = 8'($urandom_range(15));
        end
        else if (pick < 35)
            idx = $urandom_range(1) ? SYM_ZRL : SYM_EOB;
        else if (pick < 80)
            idx = run_size($urandom_range(3), $urandom_range(1, 6));
        else
            idx = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 8)
            len = 5'd0;
        else if (pick < 16)
            len = 5'($urandom_range(17, 31));
        else
            len = 5'($urandom_range(1, 16));
        send_item(cmd, rand_value(), idx, 16'($urandom_range(65535)), len);
    endtask

    task automatic wait_drained();
        coef_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // blocks rotate between dense, sparse (long runs, EOB) and all-zero but the DC and last positions
    task automatic send_blocks(input int count);
        int                 blk;
        int                 pos;
        blk_kind_t          kind;
        logic signed [10:0] value;
        blk = 0;
        while (blk < count)
        begin
            pos  = coef_idx % BLOCK_LEN;
            kind = blk_kind_t'((coef_idx / BLOCK_LEN) % 3);
            if (pos == 0)
            begin
                idle_on = (kind != BLK_SPARSE);
                if (kind == BLK_TAIL)
                    wait_drained();
            end
            if ($urandom_range(99) < 6)
            begin
                if ($urandom_range(5) == 0)
                    send_item(CMD_UNUSED, rand_value(), 8'($urandom_range(255)),
                              16'($urandom_range(65535)), 5'($urandom_range(31)));
                else
                    send_rand_write();
            end
            if (pos == 0)
                value = rand_value();
            else
                case (kind)
                    BLK_DENSE:  value = ($urandom_range(99) < 40) ? rand_value() : 11'sd0;
                    BLK_SPARSE: value = ($urandom_range(99) < 6) ? rand_value() : 11'sd0;
                    default:    value = (pos == BLOCK_LEN - 1) ? rand_value() : 11'sd0;
                endcase
            send_coef(value);
            if (pos == BLOCK_LEN - 1)
                blk++;
        end
    endtask

    // chunk side: random stalls, plus one long hold-off on request
    initial
    begin
        chunk_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                chunk_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                chunk_ch.ready <= !(idle_on && $urandom_range(99) < 8);
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        hold_req            = 1'b0;
        coef_idx            = 0;
        coef_ch.valid       = 1'b0;
        coef_ch.cmd         = CMD_COEF;
        coef_ch.coef_value  = '0;
        coef_ch.table_index = '0;
        coef_ch.code_bits   = '0;
        coef_ch.code_length = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(CMD_DC_WR, 11'sd0, 8'd0, 16'h0000, 5'd2);
        // length above 16 is clipped
        send_item(CMD_DC_WR, 11'sd0, 8'd11, 16'hFFFF, 5'd31);
        // dc index past the table is dropped
        send_item(CMD_DC_WR, -11'sd1, 8'd12, 16'h1234, 5'd4);
        send_item(CMD_DC_WR, 11'sd1023, 8'd255, 16'h5555, 5'd16);
        send_item(CMD_AC_WR, 11'sd0, SYM_EOB, 16'h000A, 5'd4);
        send_item(CMD_AC_WR, 11'sd0, SYM_ZRL, 16'h07F9, 5'd11);
        send_item(CMD_AC_WR, 11'sd0, run_size(0, 1), 16'hFFF0, 5'd2);
        send_item(CMD_AC_WR, 11'sd0, run_size(15, 11), 16'hABCD, 5'd16);
        send_item(CMD_AC_WR, 11'sd0, run_size(0, 11), 16'hFFFF, 5'd0);
        send_item(CMD_UNUSED, 11'h400, 8'hFF, 16'hFFFF, 5'd31);
        // dc at -1024 (category eleven), then ac extremes incl. -1024
        send_coef(11'h400);
        send_coef(11'sd1);
        send_coef(11'h400);
        send_coef(11'sd1023);
        send_coef(11'sd0);
        send_coef(-11'sd1);

        repeat (TABLE_LOADS) send_rand_write();
        hold_req = 1'b1;
        send_blocks(RAND_BLOCKS);

        idle_on = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        fails = mismatches + outstanding;
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/jbec_pkg.sv
rtl/core/jbec_if.sv
rtl/core/jbec_code_store.sv
rtl/core/jbec_chunk_seq.sv
rtl/core/jpeg_block_entropy_coder.sv
rtl/core/jbec_checker.sv
tb/jbec_chunk_checker.sv
tb/tb.sv
